// File: hdl/cft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants of the command file tokenizer: token kinds,
// error codes, the result item and the push bundle between lexer and queue.
// ----------------------------------------------------------------------------
package cft_pkg;

    localparam int LINE_BITS = 20;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        TOK_IDENT  = 4'd0,
        TOK_LPAREN = 4'd1,
        TOK_RPAREN = 4'd2,
        TOK_NUMBER = 4'd3,
        TOK_STRING = 4'd4,
        TOK_EQUAL  = 4'd5,
        TOK_SEMI   = 4'd6,
        TOK_LBRACE = 4'd7,
        TOK_RBRACE = 4'd8,
        TOK_GT     = 4'd9,
        TOK_PIPE   = 4'd10,
        TOK_SHL    = 4'd11,
        TOK_COMMA  = 4'd12,
        TOK_LE     = 4'd13,
        TOK_END    = 4'd14
    } t_token_kind;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_OPEN_STR   = 3'd1,
        ERR_BAD_ESC    = 3'd2,
        ERR_OPEN_LIT   = 3'd3,
        ERR_LIT_LEN    = 3'd4,
        ERR_OPEN_COM   = 3'd5,
        ERR_BAD_CHAR   = 3'd6
    } t_error_code;

    typedef struct packed {
        t_token_kind kind;
        logic        text_valid;
        logic [7:0]  text_char;
        logic        done;
        logic [31:0] value;
        logic [19:0] line;
        t_error_code err;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// File: hdl/command_file_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_file_tokenizer
// Byte-stream tokenizer for command files: skips blanks and comments, gives
// punctuation, numbers, character literals, identifier and string text.
//
//   channel  direction  handshake                  payload
//   input    in         i_in_valid / o_in_stall    i_in_byte, i_end_of_input
//   output   out        o_out_valid / i_out_stall  o_token_kind .. o_last
//
// one input item is taken per cycle while the input does not stall; its
// results go into a four-entry queue in the same cycle and leave one per
// cycle while the output is not stalled. the input stalls while fewer than
// two queue entries are free. reset returns the lexer to idle with line one
// and empties the queue.
// ----------------------------------------------------------------------------
module command_file_tokenizer import cft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_token_kind,
    output logic        o_text_valid,
    output logic [7:0]  o_text_char,
    output logic        o_token_done,
    output logic [31:0] o_number_value,
    output logic [19:0] o_start_line,
    output logic [2:0]  o_error_code,
    output logic        o_last
);

    t_push   push;
    t_result head;
    logic    full;
    logic    step;

    assign o_in_stall = full;
    assign step       = i_in_valid && !full;

    cft_lexer u_lexer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (push)
    );

    cft_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_token_kind   = head.kind;
    assign o_text_valid   = head.text_valid;
    assign o_text_char    = head.text_char;
    assign o_token_done   = head.done;
    assign o_number_value = head.value;
    assign o_start_line   = head.line;
    assign o_error_code   = head.err;
    assign o_last         = head.last;

endmodule

// File: hdl/cft_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_lexer
// Lexer state and the single-pass decode of one input byte into up to two
// result items, pushed to the output queue on the cycle the item is taken.
// ----------------------------------------------------------------------------
module cft_lexer import cft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output t_push       o_push
);

    typedef enum logic [13:0] {
        MODE_IDLE  = 14'b00000000000001,
        MODE_SLASH = 14'b00000000000010,
        MODE_LCOM  = 14'b00000000000100,
        MODE_BCOM  = 14'b00000000001000,
        MODE_BSTAR = 14'b00000000010000,
        MODE_LT    = 14'b00000000100000,
        MODE_IDENT = 14'b00000001000000,
        MODE_DEC   = 14'b00000010000000,
        MODE_ZERO  = 14'b00000100000000,
        MODE_HEX   = 14'b00001000000000,
        MODE_STR   = 14'b00010000000000,
        MODE_ESC   = 14'b00100000000000,
        MODE_CHR   = 14'b01000000000000,
        MODE_ERR   = 14'b10000000000000
    } t_mode;

    t_mode                r_mode, n_mode;
    logic [31:0]          r_acc, n_acc;
    logic [2:0]           r_cnt, n_cnt;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [LINE_BITS-1:0] r_tline, n_tline;
    t_error_code          r_err, n_err;

    logic        pre_vld, main_vld, do_start, fail_vld;
    t_result     pre_res, main_res;
    t_error_code fail_code, eoi_err;
    logic [19:0] line20, tline20;
    logic [7:0]  c;
    logic        c_digit, c_alpha, c_hex, c_blank;
    logic [3:0]  c_hexval;
    t_result     slot0, slot1;
    logic [1:0]  nres;

    function automatic logic [19:0] to_line20(input logic [LINE_BITS-1:0] l);
        logic [LINE_BITS+19:0] e;
        e = {20'd0, l};
        return e[19:0];
    endfunction

    function automatic t_result mk(input t_token_kind kind, input logic tv,
                                   input logic [7:0] ch, input logic done,
                                   input logic [31:0] val, input logic [19:0] line,
                                   input t_error_code err);
        t_result r;
        r.kind       = kind;
        r.text_valid = tv;
        r.text_char  = ch;
        r.done       = done;
        r.value      = val;
        r.line       = line;
        r.err        = err;
        r.last       = 1'b0;
        return r;
    endfunction

    assign c        = i_in_byte;
    assign line20   = to_line20(r_line);
    assign tline20  = to_line20(r_tline);
    assign c_digit  = (c >= "0") && (c <= "9");
    assign c_alpha  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign c_blank  = (c == " ") || (c == "\t") || (c == "\n") || (c == "\r");

    always_comb begin
        c_hex    = 1'b1;
        c_hexval = 4'd0;
        if (c_digit) begin
            c_hexval = 4'(c - "0");
        end else if ((c >= "a") && (c <= "f")) begin
            c_hexval = 4'(c - "a" + 8'd10);
        end else if ((c >= "A") && (c <= "F")) begin
            c_hexval = 4'(c - "A" + 8'd10);
        end else begin
            c_hex = 1'b0;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_line    = r_line;
        n_tline   = r_tline;
        n_err     = r_err;
        pre_vld   = 1'b0;
        main_vld  = 1'b0;
        pre_res   = '0;
        main_res  = '0;
        do_start  = 1'b0;
        fail_vld  = 1'b0;
        fail_code = ERR_NONE;
        eoi_err   = r_err;

        if (i_end_of_input) begin
            unique case (r_mode)
                MODE_IDENT: begin
                    pre_vld = 1'b1;
                    pre_res = mk(TOK_IDENT, 1'b0, 8'd0, 1'b1, 32'd0, tline20, ERR_NONE);
                end
                MODE_DEC, MODE_ZERO, MODE_HEX: begin
                    pre_vld = 1'b1;
                    pre_res = mk(TOK_NUMBER, 1'b0, 8'd0, 1'b1, r_acc, tline20, ERR_NONE);
                end
                MODE_SLASH, MODE_LT: eoi_err = ERR_BAD_CHAR;
                MODE_BCOM, MODE_BSTAR: eoi_err = ERR_OPEN_COM;
                MODE_STR, MODE_ESC: eoi_err = ERR_OPEN_STR;
                MODE_CHR: eoi_err = ERR_OPEN_LIT;
                default: ;
            endcase
            main_vld = 1'b1;
            main_res = mk(TOK_END, 1'b0, 8'd0, 1'b1, 32'd0, line20, eoi_err);
            n_mode   = MODE_IDLE;
            n_acc    = 32'd0;
            n_cnt    = 3'd0;
            n_line   = LINE_ONE;
            n_tline  = LINE_ONE;
            n_err    = ERR_NONE;
        end else begin
            unique case (r_mode)
                MODE_IDLE: do_start = 1'b1;
                MODE_SLASH: begin
                    if (c == "/") begin
                        n_mode = MODE_LCOM;
                    end else if (c == "*") begin
                        n_mode = MODE_BCOM;
                    end else begin
                        fail_vld  = 1'b1;
                        fail_code = ERR_BAD_CHAR;
                    end
                end
                MODE_LCOM: begin
                    if (c == "\n") n_mode = MODE_IDLE;
                end
                MODE_BCOM: begin
                    if (c == "*") n_mode = MODE_BSTAR;
                end
                MODE_BSTAR: begin
                    if (c == "/") begin
                        n_mode = MODE_IDLE;
                    end else if (c != "*") begin
                        n_mode = MODE_BCOM;
                    end
                end
                MODE_LT: begin
                    if (c == "<") begin
                        main_vld = 1'b1;
                        main_res = mk(TOK_SHL, 1'b0, 8'd0, 1'b1, 32'd0, tline20, ERR_NONE);
                        n_mode   = MODE_IDLE;
                    end else if (c == "=") begin
                        main_vld = 1'b1;
                        main_res = mk(TOK_LE, 1'b0, 8'd0, 1'b1, 32'd0, tline20, ERR_NONE);
                        n_mode   = MODE_IDLE;
                    end else begin
                        fail_vld  = 1'b1;
                        fail_code = ERR_BAD_CHAR;
                    end
                end
                MODE_IDENT: begin
                    if (c_alpha || c_digit || (c == "_")) begin
                        main_vld = 1'b1;
                        main_res = mk(TOK_IDENT, 1'b1, c, 1'b0, 32'd0, tline20, ERR_NONE);
                    end else begin
                        pre_vld  = 1'b1;
                        pre_res  = mk(TOK_IDENT, 1'b0, 8'd0, 1'b1, 32'd0, tline20, ERR_NONE);
                        do_start = 1'b1;
                    end
                end
                MODE_ZERO, MODE_DEC: begin
                    if ((r_mode == MODE_ZERO) && (c == "x")) begin
                        n_mode = MODE_HEX;
                        n_acc  = 32'd0;
                    end else if (c_digit) begin
                        n_mode = MODE_DEC;
                        n_acc  = (r_acc << 3) + (r_acc << 1) + {28'd0, c_hexval};
                    end else begin
                        pre_vld  = 1'b1;
                        pre_res  = mk(TOK_NUMBER, 1'b0, 8'd0, 1'b1, r_acc, tline20, ERR_NONE);
                        do_start = 1'b1;
                    end
                end
                MODE_HEX: begin
                    if (c_hex) begin
                        n_acc = {r_acc[27:0], c_hexval};
                    end else begin
                        pre_vld  = 1'b1;
                        pre_res  = mk(TOK_NUMBER, 1'b0, 8'd0, 1'b1, r_acc, tline20, ERR_NONE);
                        do_start = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (c == "\"") begin
                        main_vld = 1'b1;
                        main_res = mk(TOK_STRING, 1'b0, 8'd0, 1'b1, 32'd0, tline20, ERR_NONE);
                        n_mode   = MODE_IDLE;
                    end else if (c == "\\") begin
                        n_mode = MODE_ESC;
                    end else begin
                        main_vld = 1'b1;
                        main_res = mk(TOK_STRING, 1'b1, c, 1'b0, 32'd0, tline20, ERR_NONE);
                    end
                end
                MODE_ESC: begin
                    if ((c == "\\") || (c == "'") || (c == "\"")) begin
                        main_vld = 1'b1;
                        main_res = mk(TOK_STRING, 1'b1, c, 1'b0, 32'd0, tline20, ERR_NONE);
                        n_mode   = MODE_STR;
                    end else begin
                        fail_vld  = 1'b1;
                        fail_code = ERR_BAD_ESC;
                    end
                end
                MODE_CHR: begin
                    if (c == "'") begin
                        if ((r_cnt == 3'd0) || (r_cnt > 3'd4)) begin
                            fail_vld  = 1'b1;
                            fail_code = ERR_LIT_LEN;
                        end else begin
                            main_vld = 1'b1;
                            main_res = mk(TOK_NUMBER, 1'b0, 8'd0, 1'b1, r_acc, tline20,
                                          ERR_NONE);
                            n_mode   = MODE_IDLE;
                        end
                    end else begin
                        n_acc = {r_acc[23:0], c};
                        if (r_cnt < 3'd5) n_cnt = r_cnt + 3'd1;
                    end
                end
                MODE_ERR: ;
                default: n_mode = MODE_ERR;
            endcase

            if (do_start) begin
                n_mode = MODE_IDLE;
                if (!c_blank) begin
                    n_tline  = r_line;
                    main_vld = 1'b1;
                    main_res = mk(TOK_END, 1'b0, 8'd0, 1'b1, 32'd0, line20, ERR_NONE);
                    case (c)
                        "(": main_res.kind = TOK_LPAREN;
                        ")": main_res.kind = TOK_RPAREN;
                        "=": main_res.kind = TOK_EQUAL;
                        ";": main_res.kind = TOK_SEMI;
                        "{": main_res.kind = TOK_LBRACE;
                        "}": main_res.kind = TOK_RBRACE;
                        ">": main_res.kind = TOK_GT;
                        "|": main_res.kind = TOK_PIPE;
                        ",": main_res.kind = TOK_COMMA;
                        default: begin
                            main_vld = 1'b0;
                            if (c == "/") begin
                                n_mode = MODE_SLASH;
                            end else if (c == "<") begin
                                n_mode = MODE_LT;
                            end else if (c == "\"") begin
                                n_mode = MODE_STR;
                            end else if (c == "'") begin
                                n_mode = MODE_CHR;
                                n_acc  = 32'd0;
                                n_cnt  = 3'd0;
                            end else if (c_digit) begin
                                n_acc  = {28'd0, c_hexval};
                                n_mode = (c == "0") ? MODE_ZERO : MODE_DEC;
                            end else if (c_alpha || (c == "_")) begin
                                n_mode   = MODE_IDENT;
                                main_vld = 1'b1;
                                main_res = mk(TOK_IDENT, 1'b1, c, 1'b0, 32'd0, line20,
                                              ERR_NONE);
                            end else begin
                                fail_vld  = 1'b1;
                                fail_code = ERR_BAD_CHAR;
                            end
                        end
                    endcase
                end
            end

            if (fail_vld) begin
                n_err    = fail_code;
                n_mode   = MODE_ERR;
                main_vld = 1'b1;
                main_res = mk(TOK_END, 1'b0, 8'd0, 1'b0, 32'd0, line20, fail_code);
            end

            if ((c == "\n") && (r_line != LINE_MAX)) n_line = r_line + LINE_ONE;
        end
    end

    // pack results: pending token first, then what the byte itself gives
    always_comb begin
        slot0 = pre_vld ? pre_res : main_res;
        slot1 = main_res;
        nres  = {1'b0, pre_vld} + {1'b0, main_vld};
        if (nres == 2'd2) begin
            slot1.last = 1'b1;
        end else begin
            slot0.last = 1'b1;
        end
        o_push.count = i_step ? nres : 2'd0;
        o_push.r0    = slot0;
        o_push.r1    = slot1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_acc   <= 32'd0;
            r_cnt   <= 3'd0;
            r_line  <= LINE_ONE;
            r_tline <= LINE_ONE;
            r_err   <= ERR_NONE;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_line  <= n_line;
            r_tline <= n_tline;
            r_err   <= n_err;
        end
    end

endmodule

// File: hdl/cft_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_out_queue
// Small result queue: takes up to two result items per cycle from the lexer
// and hands them out one per cycle on the output channel while i_pop is high.
// ----------------------------------------------------------------------------
module cft_out_queue import cft_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_head
);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_head, n_head;
    logic [QUEUE_AW-1:0] r_tail, n_tail;
    logic [QUEUE_AW:0]   r_count, n_count;
    logic                pop;

    // room for two more items is needed before a new input is taken
    assign o_full  = r_count > (QUEUE_AW+1)'(QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_head];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_head  = pop ? r_head + QUEUE_AW'(1) : r_head;
        n_tail  = r_tail + QUEUE_AW'(i_push.count);
        n_count = r_count + (QUEUE_AW+1)'(i_push.count) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_tail] <= i_push.r0;
        if (i_push.count == 2'd2) r_mem[r_tail + QUEUE_AW'(1)] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

// File: dv/command_file_tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_file_tokenizer_checker
// Watches the byte and token channels of the tokenizer. Each accepted byte
// runs through a lexer kept here, which queues the tokens the block must give
// for it; each accepted token is compared field by field with the oldest one
// queued. Mismatches and tokens nobody asked for are counted for the top.
// ----------------------------------------------------------------------------
module command_file_tokenizer_checker import cft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_token_kind,
    input  logic        i_text_valid,
    input  logic [7:0]  i_text_char,
    input  logic        i_token_done,
    input  logic [31:0] i_number_value,
    input  logic [19:0] i_start_line,
    input  logic [2:0]  i_error_code,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [3:0] {
        LX_IDLE, LX_SLASH, LX_LCOM, LX_BCOM, LX_BSTAR, LX_LT, LX_IDENT,
        LX_DEC, LX_ZERO, LX_HEX, LX_STR, LX_ESC, LX_CHR, LX_ERR
    } t_lex_mode;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    t_lex_mode   lex;
    logic [31:0] acc;
    logic [2:0]  lit_cnt;
    logic [19:0] cur_line;
    logic [19:0] tok_line;
    t_error_code sticky;

    t_result byte_tokens[$];
    t_result pending_tokens[$];
    int      results_seen;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit(t_token_kind kind, logic tv, logic [7:0] ch, logic done,
                                 logic [31:0] val, logic [19:0] line, t_error_code err);
        t_result r;
        if (byte_tokens.size() >= 2) return;
        r.kind       = kind;
        r.text_valid = tv;
        r.text_char  = ch;
        r.done       = done;
        r.value      = val;
        r.line       = line;
        r.err        = err;
        r.last       = 1'b0;
        byte_tokens.push_back(r);
    endfunction

    function automatic void clear_state();
        lex      = LX_IDLE;
        acc      = '0;
        lit_cnt  = '0;
        cur_line = LINE_ONE;
        tok_line = LINE_ONE;
        sticky   = ERR_NONE;
    endfunction

    function automatic void raise_error(t_error_code code);
        sticky = code;
        lex    = LX_ERR;
        emit(TOK_END, 1'b0, 8'h00, 1'b0, 32'h0, cur_line, code);
    endfunction

    function automatic void flush_pending();
        if (lex == LX_IDENT)
            emit(TOK_IDENT, 1'b0, 8'h00, 1'b1, 32'h0, tok_line, ERR_NONE);
        else
            emit(TOK_NUMBER, 1'b0, 8'h00, 1'b1, acc, tok_line, ERR_NONE);
        lex = LX_IDLE;
    endfunction

    function automatic void begin_token(logic [7:0] c);
        t_token_kind kind;
        bit          hit;
        lex = LX_IDLE;
        if (c == CH_SP || c == CH_TAB || c == CH_NL || c == CH_CR) return;
        tok_line = cur_line;
        hit = 1'b1;
        case (c)
            "(": kind = TOK_LPAREN;
            ")": kind = TOK_RPAREN;
            "=": kind = TOK_EQUAL;
            ";": kind = TOK_SEMI;
            "{": kind = TOK_LBRACE;
            "}": kind = TOK_RBRACE;
            ">": kind = TOK_GT;
            "|": kind = TOK_PIPE;
            ",": kind = TOK_COMMA;
            default: hit = 1'b0;
        endcase
        if (hit) begin
            emit(kind, 1'b0, 8'h00, 1'b1, 32'h0, tok_line, ERR_NONE);
            return;
        end
        case (c)
            "/": lex = LX_SLASH;
            "<": lex = LX_LT;
            CH_DQUOTE: lex = LX_STR;
            CH_SQUOTE: begin
                lex     = LX_CHR;
                acc     = '0;
                lit_cnt = '0;
            end
            default: begin
                if (is_digit(c)) begin
                    acc = 32'(c - "0");
                    lex = (c == "0") ? LX_ZERO : LX_DEC;
                end else if (is_letter(c) || c == "_") begin
                    lex = LX_IDENT;
                    emit(TOK_IDENT, 1'b1, c, 1'b0, 32'h0, tok_line, ERR_NONE);
                end else begin
                    raise_error(ERR_BAD_CHAR);
                end
            end
        endcase
    endfunction

    function automatic void extend_decimal(logic [7:0] c);
        if (is_digit(c)) begin
            acc = acc * 32'd10 + 32'(c - "0");
        end else begin
            flush_pending();
            begin_token(c);
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] c, logic eoi);
        t_error_code code;
        t_result     r;
        byte_tokens.delete();
        if (eoi) begin
            code = sticky;
            case (lex)
                LX_IDENT, LX_DEC, LX_ZERO, LX_HEX: flush_pending();
                LX_SLASH, LX_LT: code = ERR_BAD_CHAR;
                LX_BCOM, LX_BSTAR: code = ERR_OPEN_COM;
                LX_STR, LX_ESC: code = ERR_OPEN_STR;
                LX_CHR: code = ERR_OPEN_LIT;
                default: ;
            endcase
            emit(TOK_END, 1'b0, 8'h00, 1'b1, 32'h0, cur_line, code);
            clear_state();
        end else begin
            case (lex)
                LX_IDLE: begin_token(c);
                LX_SLASH: begin
                    if (c == "/") lex = LX_LCOM;
                    else if (c == "*") lex = LX_BCOM;
                    else raise_error(ERR_BAD_CHAR);
                end
                LX_LCOM: if (c == CH_NL) lex = LX_IDLE;
                LX_BCOM: if (c == "*") lex = LX_BSTAR;
                LX_BSTAR: begin
                    if (c == "/") lex = LX_IDLE;
                    else if (c != "*") lex = LX_BCOM;
                end
                LX_LT: begin
                    if (c == "<") begin
                        emit(TOK_SHL, 1'b0, 8'h00, 1'b1, 32'h0, tok_line, ERR_NONE);
                        lex = LX_IDLE;
                    end else if (c == "=") begin
                        emit(TOK_LE, 1'b0, 8'h00, 1'b1, 32'h0, tok_line, ERR_NONE);
                        lex = LX_IDLE;
                    end else begin
                        raise_error(ERR_BAD_CHAR);
                    end
                end
                LX_IDENT: begin
                    if (is_letter(c) || is_digit(c) || c == "_") begin
                        emit(TOK_IDENT, 1'b1, c, 1'b0, 32'h0, tok_line, ERR_NONE);
                    end else begin
                        flush_pending();
                        begin_token(c);
                    end
                end
                LX_ZERO: begin
                    if (c == "x") begin
                        lex = LX_HEX;
                        acc = '0;
                    end else begin
                        lex = LX_DEC;
                        extend_decimal(c);
                    end
                end
                LX_DEC: extend_decimal(c);
                LX_HEX: begin
                    if (is_digit(c)) begin
                        acc = {acc[27:0], c[3:0]};
                    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
                        acc = {acc[27:0], c[3:0] + 4'd9};
                    end else begin
                        flush_pending();
                        begin_token(c);
                    end
                end
                LX_STR: begin
                    if (c == CH_DQUOTE) begin
                        emit(TOK_STRING, 1'b0, 8'h00, 1'b1, 32'h0, tok_line, ERR_NONE);
                        lex = LX_IDLE;
                    end else if (c == CH_BSLASH) begin
                        lex = LX_ESC;
                    end else begin
                        emit(TOK_STRING, 1'b1, c, 1'b0, 32'h0, tok_line, ERR_NONE);
                    end
                end
                LX_ESC: begin
                    if (c == CH_BSLASH || c == CH_SQUOTE || c == CH_DQUOTE) begin
                        emit(TOK_STRING, 1'b1, c, 1'b0, 32'h0, tok_line, ERR_NONE);
                        lex = LX_STR;
                    end else begin
                        raise_error(ERR_BAD_ESC);
                    end
                end
                LX_CHR: begin
                    if (c == CH_SQUOTE) begin
                        if (lit_cnt == 3'd0 || lit_cnt > 3'd4) begin
                            raise_error(ERR_LIT_LEN);
                        end else begin
                            emit(TOK_NUMBER, 1'b0, 8'h00, 1'b1, acc, tok_line, ERR_NONE);
                            lex = LX_IDLE;
                        end
                    end else begin
                        acc = {acc[23:0], c};
                        if (lit_cnt < 3'd5) lit_cnt = lit_cnt + 3'd1;
                    end
                end
                default: lex = LX_ERR;
            endcase
            if (c == CH_NL && cur_line != LINE_MAX) cur_line = cur_line + 20'd1;
        end
        if (byte_tokens.size() > 0) begin
            r = byte_tokens.pop_back();
            r.last = 1'b1;
            byte_tokens.push_back(r);
        end
        foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("checker: result %0d: %s (got %0h, want %0h)",
                 results_seen, what, got, want);
        o_fail_count++;
    endtask

    task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch({what, " differs"}, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_state();
            pending_tokens.delete();
            results_seen = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_tokens.size() == 0) begin
                    report_mismatch("token with none expected", 32'(i_token_kind), 32'h0);
                end else begin
                    want = pending_tokens.pop_front();
                    compare_field("token_kind", 32'(i_token_kind), 32'(want.kind));
                    compare_field("text_valid", 32'(i_text_valid), 32'(want.text_valid));
                    compare_field("text_char", 32'(i_text_char), 32'(want.text_char));
                    compare_field("token_done", 32'(i_token_done), 32'(want.done));
                    compare_field("number_value", i_number_value, want.value);
                    compare_field("start_line", 32'(i_start_line), 32'(want.line));
                    compare_field("error_code", 32'(i_error_code), 32'(want.err));
                    compare_field("last", 32'(i_last), 32'(want.last));
                end
                results_seen++;
            end
            if (i_in_valid && !i_in_stall) tokenize_byte(i_in_byte, i_end_of_input);
        end
        o_pending = pending_tokens.size();
    end

endmodule

// File: dv/command_file_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_file_tokenizer_tb
// Feeds the tokenizer a short hand-written text, then random command-file
// streams built from well-formed tokens, comments, strings and literals, some
// ending broken or left open. Both channels pause at random in bursts. The
// checker beside the block predicts and compares every token.
// ----------------------------------------------------------------------------
module command_file_tokenizer_tb;
    import cft_pkg::*;

    localparam int ITEM_TARGET = 850;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [7:0] NL     = 8'h0A;
    localparam logic [7:0] DQUOTE = 8'h22;
    localparam logic [7:0] SQUOTE = 8'h27;
    localparam logic [7:0] BSLASH = 8'h5C;

    localparam string PUNCT      = "()=;{}>|,";
    localparam string IDENT_LEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string IDENT_TAIL =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string DIGITS     = "0123456789";
    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
    localparam string BAD_CHARS  = "!#$%&*+-.:?@[]^~";
    localparam string ESCAPED    = "\\'\"";

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        in_eoi;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  token_kind;
    logic        text_valid;
    logic [7:0]  text_char;
    logic        token_done;
    logic [31:0] number_value;
    logic [19:0] start_line;
    logic [2:0]  error_code;
    logic        last;

    int         fail_count;
    int         pending;
    int         sent;
    int         cycles = 0;
    bit         idle_on;
    logic [7:0] text_q[$];

    command_file_tokenizer uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_end_of_input (in_eoi),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_token_kind   (token_kind),
        .o_text_valid   (text_valid),
        .o_text_char    (text_char),
        .o_token_done   (token_done),
        .o_number_value (number_value),
        .o_start_line   (start_line),
        .o_error_code   (error_code),
        .o_last         (last)
    );

    command_file_tokenizer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_end_of_input (in_eoi),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_token_kind   (token_kind),
        .i_text_valid   (text_valid),
        .i_text_char    (text_char),
        .i_token_done   (token_done),
        .i_number_value (number_value),
        .i_start_line   (start_line),
        .i_error_code   (error_code),
        .i_last         (last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] pick_char(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    // one token or comment, or with tail set a broken or unfinished ending
    function automatic void add_snippet(bit tail);
        int         pick;
        int         sel;
        bit         alt;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        alt  = 1'($urandom_range(0, 1));
        if (tail) begin
            sel = $urandom_range(0, 8);
            case (sel)
                0: begin
                    text_q.push_back(DQUOTE);
                    repeat ($urandom_range(0, 3)) text_q.push_back(pick_char(IDENT_TAIL));
                    text_q.push_back(BSLASH);
                    do b = 8'($urandom_range(0, 255));
                    while (b == BSLASH || b == SQUOTE || b == DQUOTE);
                    text_q.push_back(b);
                end
                1: begin
                    text_q.push_back("/");
                    if (alt) begin
                        do b = 8'($urandom_range(0, 255)); while (b == "/" || b == "*");
                        text_q.push_back(b);
                    end
                end
                2: begin
                    text_q.push_back("<");
                    if (alt) begin
                        do b = 8'($urandom_range(0, 255)); while (b == "<" || b == "=");
                        text_q.push_back(b);
                    end
                end
                3: text_q.push_back(alt ? 8'($urandom_range(128, 255)) : pick_char(BAD_CHARS));
                4: begin
                    text_q.push_back(SQUOTE);
                    if (alt) begin
                        repeat ($urandom_range(5, 7)) begin
                            do b = 8'($urandom_range(0, 255)); while (b == SQUOTE);
                            text_q.push_back(b);
                        end
                    end
                    text_q.push_back(SQUOTE);
                end
                5: begin
                    text_q.push_back(DQUOTE);
                    repeat ($urandom_range(0, 4)) text_q.push_back(pick_char(IDENT_TAIL));
                    if (alt) text_q.push_back(BSLASH);
                end
                6: begin
                    push_text("/*");
                    repeat ($urandom_range(0, 4)) text_q.push_back(pick_char(IDENT_TAIL));
                    if (alt) text_q.push_back("*");
                end
                7: begin
                    text_q.push_back(SQUOTE);
                    repeat ($urandom_range(0, 3)) text_q.push_back(pick_char(IDENT_TAIL));
                end
                default: begin
                    push_text("//");
                    repeat ($urandom_range(0, 3)) text_q.push_back(pick_char(IDENT_TAIL));
                end
            endcase
            // bytes after an error are dropped, newlines still counted
            if (sel < 5)
                repeat ($urandom_range(0, 3)) text_q.push_back(alt ? NL : 8'($urandom));
        end else if (pick < 12) begin
            case ($urandom_range(0, 3))
                0: b = " ";
                1: b = 8'h09;
                2: b = 8'h0D;
                default: b = NL;
            endcase
            text_q.push_back(b);
        end else if (pick < 30) begin
            text_q.push_back(pick_char(PUNCT));
        end else if (pick < 36) begin
            text_q.push_back("<");
            text_q.push_back(alt ? "<" : "=");
        end else if (pick < 50) begin
            text_q.push_back(pick_char(IDENT_LEAD));
            repeat ($urandom_range(0, 7)) text_q.push_back(pick_char(IDENT_TAIL));
        end else if (pick < 60) begin
            repeat ($urandom_range(1, 12)) text_q.push_back(pick_char(DIGITS));
        end else if (pick < 68) begin
            push_text("0x");
            repeat ($urandom_range(0, 9)) text_q.push_back(pick_char(HEX_DIGITS));
        end else if (pick < 78) begin
            text_q.push_back(DQUOTE);
            repeat ($urandom_range(0, 8)) begin
                if ($urandom_range(0, 5) == 0) begin
                    text_q.push_back(BSLASH);
                    text_q.push_back(pick_char(ESCAPED));
                end else begin
                    do b = 8'($urandom_range(0, 255)); while (b == DQUOTE || b == BSLASH);
                    text_q.push_back(b);
                end
            end
            text_q.push_back(DQUOTE);
        end else if (pick < 86) begin
            text_q.push_back(SQUOTE);
            repeat ($urandom_range(1, 4)) begin
                do b = 8'($urandom_range(0, 255)); while (b == SQUOTE);
                text_q.push_back(b);
            end
            text_q.push_back(SQUOTE);
        end else if (pick < 93) begin
            push_text("//");
            repeat ($urandom_range(0, 6)) begin
                do b = 8'($urandom_range(0, 255)); while (b == NL);
                text_q.push_back(b);
            end
            text_q.push_back(NL);
        end else begin
            push_text("/*");
            // a slash right after the opening star must not close the comment
            if (alt) text_q.push_back("/");
            repeat ($urandom_range(0, 6)) begin
                b = 8'($urandom_range(0, 255));
                text_q.push_back(b == "/" ? 8'("*") : b);
            end
            push_text("*/");
        end
    endfunction

    task automatic send_item(logic [7:0] b, logic eoi);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_eoi   <= eoi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_stream();
        foreach (text_q[i]) send_item(text_q[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        text_q.delete();
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h00;
        in_eoi   = 1'b0;
        idle_on  = 1'b1;
        sent     = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // every token kind, an unsigned literal byte and empty hex
        push_text("(_)={0xF;0x,\"a\"'");
        text_q.push_back(8'hFF);
        push_text("'}>|,<<<=");
        text_q.push_back(NL);
        send_stream();
        text_q.push_back(8'h00);
        send_stream();

        while (sent < ITEM_TARGET) begin
            idle_on = (sent < 300) || (sent >= 450 && sent < 700);
            repeat ($urandom_range(1, 16)) add_snippet(1'b0);
            if ($urandom_range(0, 3) == 0) add_snippet(1'b1);
            send_stream();
        end
        in_valid <= 1'b0;
        idle_on = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
